// ----- rtl/ecpsm_pkg.sv -----
// ----------------------------------------------------------------------------
// ecpsm_pkg
// Shared types, register-file map and microcode for the EC scalar multiplier.
// ----------------------------------------------------------------------------
package ecpsm_pkg;

  localparam int UPC_W = 7;
  localparam int REG_W = 5;
  localparam int CFG_IDX_W = 1;

  typedef logic [UPC_W-1:0] upc_t;
  typedef logic [REG_W-1:0] reg_idx_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_FIELD_MODULUS = 1'b0;
  localparam cfg_idx_t CFG_CURVE_COEFF_A = 1'b1;

  typedef enum logic [4:0] {
    OP_LOAD, OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_OUT,
    OP_JMP, OP_BZ, OP_BNZ, OP_BNBIT, OP_BACCINF, OP_BADDINF,
    OP_CALL, OP_RET, OP_CALLI, OP_RETI,
    OP_ADDINF_SET, OP_ACC_FROM_ADD, OP_ACC_FROM_RES, OP_ADD_FROM_RES,
    OP_RES_SET, OP_RES_CLR, OP_NEXT
  } op_t;

  // register file map
  localparam reg_idx_t R_ZERO = 5'd0;
  localparam reg_idx_t R_P    = 5'd1;
  localparam reg_idx_t R_A    = 5'd2;
  localparam reg_idx_t R_AX   = 5'd3;
  localparam reg_idx_t R_AY   = 5'd4;
  localparam reg_idx_t R_CX   = 5'd5;
  localparam reg_idx_t R_CY   = 5'd6;
  localparam reg_idx_t R_UX   = 5'd7;
  localparam reg_idx_t R_UY   = 5'd8;
  localparam reg_idx_t R_VX   = 5'd9;
  localparam reg_idx_t R_VY   = 5'd10;
  localparam reg_idx_t R_R0   = 5'd11;
  localparam reg_idx_t R_R1   = 5'd12;
  localparam reg_idx_t R_T0   = 5'd13;
  localparam reg_idx_t R_T1   = 5'd14;
  localparam reg_idx_t R_Q    = 5'd15;
  localparam reg_idx_t R_REM  = 5'd16;
  localparam reg_idx_t R_M    = 5'd17;
  localparam reg_idx_t R_TMP  = 5'd18;

  // load sources, carried in the first source field
  localparam reg_idx_t SRC_ZERO = 5'd0;
  localparam reg_idx_t SRC_ONE  = 5'd1;
  localparam reg_idx_t SRC_X    = 5'd2;
  localparam reg_idx_t SRC_Y    = 5'd3;
  localparam reg_idx_t SRC_P    = 5'd4;
  localparam reg_idx_t SRC_A    = 5'd5;

  // microcode labels
  localparam upc_t U_NONE = 7'd0;
  localparam upc_t L_LOOP = 7'd16;
  localparam upc_t L_COPY = 7'd28;
  localparam upc_t L_DBL  = 7'd31;
  localparam upc_t L_NEXT = 7'd40;
  localparam upc_t L_PADD = 7'd42;
  localparam upc_t L_DIFF = 7'd56;
  localparam upc_t L_XY   = 7'd60;
  localparam upc_t L_PINF = 7'd69;
  localparam upc_t L_INV  = 7'd71;
  localparam upc_t L_IL   = 7'd74;
  localparam upc_t L_IRET = 7'd85;

  typedef struct packed {
    op_t      op;
    reg_idx_t dst;
    reg_idx_t sa;
    reg_idx_t sb;
    upc_t     tgt;
  } uinstr_t;

  typedef struct packed {
    logic     start;
    op_t      op;
    reg_idx_t dst;
    reg_idx_t sa;
    reg_idx_t sb;
    logic     load_in;
    logic     load_out;
    logic     out_inf;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic zero;
  } dp_stat_t;

  function automatic uinstr_t mk(op_t op, reg_idx_t dst, reg_idx_t sa, reg_idx_t sb,
                                 upc_t tgt);
    uinstr_t u;
    u.op  = op;
    u.dst = dst;
    u.sa  = sa;
    u.sb  = sb;
    u.tgt = tgt;
    return u;
  endfunction

  function automatic logic is_dp_op(op_t op);
    return (op == OP_LOAD) || (op == OP_MOV) || (op == OP_ADD) || (op == OP_SUB) ||
           (op == OP_MUL) || (op == OP_DIV) || (op == OP_OUT);
  endfunction

  // Microprogram: reduce inputs, right-to-left double-and-add, point add and
  // doubling, extended Euclid inverse as a subroutine.
  function automatic uinstr_t ucode(upc_t addr);
    uinstr_t u;
    u = mk(OP_JMP, R_ZERO, R_ZERO, R_ZERO, U_NONE);
    case (addr)
      7'd0:  u = mk(OP_LOAD, R_ZERO, SRC_ZERO, R_ZERO, U_NONE);
      7'd1:  u = mk(OP_LOAD, R_P, SRC_P, R_ZERO, U_NONE);
      7'd2:  u = mk(OP_LOAD, R_TMP, SRC_X, R_ZERO, U_NONE);
      7'd3:  u = mk(OP_DIV, R_Q, R_TMP, R_P, U_NONE);
      7'd4:  u = mk(OP_MOV, R_AX, R_REM, R_ZERO, U_NONE);
      7'd5:  u = mk(OP_LOAD, R_TMP, SRC_Y, R_ZERO, U_NONE);
      7'd6:  u = mk(OP_DIV, R_Q, R_TMP, R_P, U_NONE);
      7'd7:  u = mk(OP_MOV, R_AY, R_REM, R_ZERO, U_NONE);
      7'd8:  u = mk(OP_LOAD, R_TMP, SRC_A, R_ZERO, U_NONE);
      7'd9:  u = mk(OP_DIV, R_Q, R_TMP, R_P, U_NONE);
      7'd10: u = mk(OP_MOV, R_A, R_REM, R_ZERO, U_NONE);
      7'd11: u = mk(OP_MOV, R_TMP, R_AX, R_ZERO, U_NONE);
      7'd12: u = mk(OP_BNZ, R_ZERO, R_ZERO, R_ZERO, L_LOOP);
      7'd13: u = mk(OP_MOV, R_TMP, R_AY, R_ZERO, U_NONE);
      7'd14: u = mk(OP_BNZ, R_ZERO, R_ZERO, R_ZERO, L_LOOP);
      7'd15: u = mk(OP_ADDINF_SET, R_ZERO, R_ZERO, R_ZERO, U_NONE);
      7'd16: u = mk(OP_BNBIT, R_ZERO, R_ZERO, R_ZERO, L_DBL);
      7'd17: u = mk(OP_BACCINF, R_ZERO, R_ZERO, R_ZERO, L_COPY);
      7'd18: u = mk(OP_BADDINF, R_ZERO, R_ZERO, R_ZERO, L_DBL);
      7'd19: u = mk(OP_MOV, R_UX, R_CX, R_ZERO, U_NONE);
      7'd20: u = mk(OP_MOV, R_UY, R_CY, R_ZERO, U_NONE);
      7'd21: u = mk(OP_MOV, R_VX, R_AX, R_ZERO, U_NONE);
      7'd22: u = mk(OP_MOV, R_VY, R_AY, R_ZERO, U_NONE);
      7'd23: u = mk(OP_CALL, R_ZERO, R_ZERO, R_ZERO, L_PADD);
      7'd24: u = mk(OP_ACC_FROM_RES, R_ZERO, R_ZERO, R_ZERO, U_NONE);
      7'd25: u = mk(OP_MOV, R_CX, R_UX, R_ZERO, U_NONE);
      7'd26: u = mk(OP_MOV, R_CY, R_UY, R_ZERO, U_NONE);
      7'd27: u = mk(OP_JMP, R_ZERO, R_ZERO, R_ZERO, L_DBL);
      7'd28: u = mk(OP_MOV, R_CX, R_AX, R_ZERO, U_NONE);
      7'd29: u = mk(OP_MOV, R_CY, R_AY, R_ZERO, U_NONE);
      7'd30: u = mk(OP_ACC_FROM_ADD, R_ZERO, R_ZERO, R_ZERO, U_NONE);
      7'd31: u = mk(OP_BADDINF, R_ZERO, R_ZERO, R_ZERO, L_NEXT);
      7'd32: u = mk(OP_MOV, R_UX, R_AX, R_ZERO, U_NONE);
      7'd33: u = mk(OP_MOV, R_UY, R_AY, R_ZERO, U_NONE);
      7'd34: u = mk(OP_MOV, R_VX, R_AX, R_ZERO, U_NONE);
      7'd35: u = mk(OP_MOV, R_VY, R_AY, R_ZERO, U_NONE);
      7'd36: u = mk(OP_CALL, R_ZERO, R_ZERO, R_ZERO, L_PADD);
      7'd37: u = mk(OP_ADD_FROM_RES, R_ZERO, R_ZERO, R_ZERO, U_NONE);
      7'd38: u = mk(OP_MOV, R_AX, R_UX, R_ZERO, U_NONE);
      7'd39: u = mk(OP_MOV, R_AY, R_UY, R_ZERO, U_NONE);
      7'd40: u = mk(OP_NEXT, R_ZERO, R_ZERO, R_ZERO, L_LOOP);
      7'd41: u = mk(OP_OUT, R_ZERO, R_CX, R_CY, U_NONE);
      7'd42: u = mk(OP_SUB, R_TMP, R_UX, R_VX, U_NONE);
      7'd43: u = mk(OP_BNZ, R_ZERO, R_ZERO, R_ZERO, L_DIFF);
      7'd44: u = mk(OP_SUB, R_TMP, R_UY, R_VY, U_NONE);
      7'd45: u = mk(OP_BNZ, R_ZERO, R_ZERO, R_ZERO, L_PINF);
      7'd46: u = mk(OP_MOV, R_TMP, R_UY, R_ZERO, U_NONE);
      7'd47: u = mk(OP_BZ, R_ZERO, R_ZERO, R_ZERO, L_PINF);
      7'd48: u = mk(OP_MUL, R_M, R_UX, R_UX, U_NONE);
      7'd49: u = mk(OP_ADD, R_TMP, R_M, R_M, U_NONE);
      7'd50: u = mk(OP_ADD, R_M, R_TMP, R_M, U_NONE);
      7'd51: u = mk(OP_ADD, R_M, R_M, R_A, U_NONE);
      7'd52: u = mk(OP_ADD, R_R1, R_UY, R_UY, U_NONE);
      7'd53: u = mk(OP_CALLI, R_ZERO, R_ZERO, R_ZERO, L_INV);
      7'd54: u = mk(OP_MUL, R_M, R_M, R_T0, U_NONE);
      7'd55: u = mk(OP_JMP, R_ZERO, R_ZERO, R_ZERO, L_XY);
      7'd56: u = mk(OP_SUB, R_M, R_UY, R_VY, U_NONE);
      7'd57: u = mk(OP_MOV, R_R1, R_TMP, R_ZERO, U_NONE);
      7'd58: u = mk(OP_CALLI, R_ZERO, R_ZERO, R_ZERO, L_INV);
      7'd59: u = mk(OP_MUL, R_M, R_M, R_T0, U_NONE);
      7'd60: u = mk(OP_MUL, R_TMP, R_M, R_M, U_NONE);
      7'd61: u = mk(OP_SUB, R_TMP, R_TMP, R_UX, U_NONE);
      7'd62: u = mk(OP_SUB, R_TMP, R_TMP, R_VX, U_NONE);
      7'd63: u = mk(OP_SUB, R_Q, R_UX, R_TMP, U_NONE);
      7'd64: u = mk(OP_MUL, R_Q, R_M, R_Q, U_NONE);
      7'd65: u = mk(OP_SUB, R_UY, R_Q, R_UY, U_NONE);
      7'd66: u = mk(OP_MOV, R_UX, R_TMP, R_ZERO, U_NONE);
      7'd67: u = mk(OP_RES_CLR, R_ZERO, R_ZERO, R_ZERO, U_NONE);
      7'd68: u = mk(OP_RET, R_ZERO, R_ZERO, R_ZERO, U_NONE);
      7'd69: u = mk(OP_RES_SET, R_ZERO, R_ZERO, R_ZERO, U_NONE);
      7'd70: u = mk(OP_RET, R_ZERO, R_ZERO, R_ZERO, U_NONE);
      7'd71: u = mk(OP_MOV, R_R0, R_P, R_ZERO, U_NONE);
      7'd72: u = mk(OP_LOAD, R_T0, SRC_ZERO, R_ZERO, U_NONE);
      7'd73: u = mk(OP_LOAD, R_T1, SRC_ONE, R_ZERO, U_NONE);
      7'd74: u = mk(OP_MOV, R_TMP, R_R1, R_ZERO, U_NONE);
      7'd75: u = mk(OP_BZ, R_ZERO, R_ZERO, R_ZERO, L_IRET);
      7'd76: u = mk(OP_DIV, R_Q, R_R0, R_R1, U_NONE);
      7'd77: u = mk(OP_ADD, R_Q, R_Q, R_ZERO, U_NONE);
      7'd78: u = mk(OP_MUL, R_Q, R_Q, R_T1, U_NONE);
      7'd79: u = mk(OP_SUB, R_Q, R_T0, R_Q, U_NONE);
      7'd80: u = mk(OP_MOV, R_R0, R_R1, R_ZERO, U_NONE);
      7'd81: u = mk(OP_MOV, R_R1, R_REM, R_ZERO, U_NONE);
      7'd82: u = mk(OP_MOV, R_T0, R_T1, R_ZERO, U_NONE);
      7'd83: u = mk(OP_MOV, R_T1, R_Q, R_ZERO, U_NONE);
      7'd84: u = mk(OP_JMP, R_ZERO, R_ZERO, R_ZERO, L_IL);
      7'd85: u = mk(OP_RETI, R_ZERO, R_ZERO, R_ZERO, U_NONE);
      default: u = mk(OP_JMP, R_ZERO, R_ZERO, R_ZERO, U_NONE);
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/ec_point_scalar_multiply.sv -----
// ----------------------------------------------------------------------------
// ec_point_scalar_multiply
// k times a point on y^2 = x^3 + a*x + b over a prime field, double-and-add.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one word: point_x, point_y,
// scalar_k. Output channel (out_valid/out_ready) returns one word per input:
// result_x, result_y and result_is_identity; the identity reads as (0,0).
// The config port writes field_modulus (index 0) and curve_coeff_a
// (index 1); write only while the block is idle. One item is in flight at
// a time. in_ready is high whenever the sequencer is idle, also while a
// finished word still waits in the output register. Run time depends on
// the data: every field op runs on a shared datapath, with a bit-serial
// multiply and a restoring divide (one bit a cycle). The extended Euclid
// inverse, one per point op, dominates. If the receiver stalls, the
// finished word holds in the output register; the next item can start,
// and parks before its own output until the slot frees. Reset clears the
// sequencer and output valid and restores the config registers to
// p = 65521 and a = 65518; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ec_point_scalar_multiply #(
  parameter int FIELD_BITS  = 16,
  parameter int SCALAR_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [FIELD_BITS-1:0]          point_x,
  input  logic [FIELD_BITS-1:0]          point_y,
  input  logic [SCALAR_BITS-1:0]         scalar_k,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [FIELD_BITS-1:0]          result_x,
  output logic [FIELD_BITS-1:0]          result_y,
  output logic                           result_is_identity,
  input  logic                           cfg_we,
  input  logic [ecpsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_BITS-1:0]          cfg_wdata
);

  logic [FIELD_BITS-1:0] field_modulus, curve_coeff_a, p_eff;
  ecpsm_pkg::dp_cmd_t    dp_cmd;
  ecpsm_pkg::dp_stat_t   dp_stat;

  // Config registers; reset values truncate to the field width.
  always_ff @(posedge clk) begin
    if (rst) begin
      field_modulus <= FIELD_BITS'(32'd65521);
      curve_coeff_a <= FIELD_BITS'(32'd65518);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ecpsm_pkg::CFG_FIELD_MODULUS: field_modulus <= cfg_wdata;
        ecpsm_pkg::CFG_CURVE_COEFF_A: curve_coeff_a <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp a degenerate modulus up to 3.
  assign p_eff = (field_modulus < FIELD_BITS'(3)) ? FIELD_BITS'(3) : field_modulus;

  ecpsm_ctrl #(
    .SCALAR_BITS (SCALAR_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .scalar_k  (scalar_k),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat)
  );

  ecpsm_dp #(
    .FIELD_BITS (FIELD_BITS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (dp_cmd),
    .stat               (dp_stat),
    .point_x            (point_x),
    .point_y            (point_y),
    .p_eff              (p_eff),
    .coeff_a            (curve_coeff_a),
    .result_x           (result_x),
    .result_y           (result_y),
    .result_is_identity (result_is_identity)
  );

endmodule

// ----- rtl/ecpsm_dp.sv -----
// ----------------------------------------------------------------------------
// ecpsm_dp
// Field datapath: register file, mod add/sub, bit-serial mod multiply and
// restoring divider, input and result registers.
// ----------------------------------------------------------------------------
module ecpsm_dp #(
  parameter int FIELD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ecpsm_pkg::dp_cmd_t      cmd,
  output ecpsm_pkg::dp_stat_t     stat,
  input  logic [FIELD_BITS-1:0]   point_x,
  input  logic [FIELD_BITS-1:0]   point_y,
  input  logic [FIELD_BITS-1:0]   p_eff,
  input  logic [FIELD_BITS-1:0]   coeff_a,
  output logic [FIELD_BITS-1:0]   result_x,
  output logic [FIELD_BITS-1:0]   result_y,
  output logic                    result_is_identity
);

  localparam int CNT_W = $clog2(FIELD_BITS);
  localparam int DEPTH = 1 << ecpsm_pkg::REG_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FIELD_BITS - 1);

  typedef enum logic [4:0] {
    D_IDLE = 5'b00001,
    D_EXEC = 5'b00010,
    D_MUL  = 5'b00100,
    D_DIV  = 5'b01000,
    D_REM  = 5'b10000
  } dstate_t;

  dstate_t                 state;
  logic [FIELD_BITS-1:0]   mem [DEPTH];
  logic [FIELD_BITS-1:0]   rd_a, rd_b, acc, shreg, in_x, in_y;
  ecpsm_pkg::op_t          op_q;
  ecpsm_pkg::reg_idx_t     dst_q, sa_q;
  logic [CNT_W-1:0]        cnt;
  logic                    zero_q;

  logic                    wr_en, done;
  ecpsm_pkg::reg_idx_t     wr_addr;
  logic [FIELD_BITS-1:0]   wr_data, load_val, sub_r, div_rem;
  logic [FIELD_BITS:0]     p_w, add_s, add_r, dbl, dbl_r, madd, mul_r, rs;
  logic                    ge;

  always_comb begin
    p_w   = {1'b0, p_eff};
    add_s = {1'b0, rd_a} + {1'b0, rd_b};
    add_r = (add_s >= p_w) ? add_s - p_w : add_s;
    sub_r = (rd_a >= rd_b) ? rd_a - rd_b : rd_a + (p_eff - rd_b);
    // multiply step: double the partial product, then add the operand on a set bit
    dbl   = {acc, 1'b0};
    dbl_r = (dbl >= p_w) ? dbl - p_w : dbl;
    madd  = dbl_r + (shreg[FIELD_BITS-1] ? {1'b0, rd_a} : '0);
    mul_r = (madd >= p_w) ? madd - p_w : madd;
    // divide step: shift in the next dividend bit, subtract when it fits
    rs      = {acc, shreg[FIELD_BITS-1]};
    ge      = (rs >= {1'b0, rd_b});
    div_rem = ge ? FIELD_BITS'(rs - {1'b0, rd_b}) : FIELD_BITS'(rs);
    case (sa_q)
      ecpsm_pkg::SRC_ONE: load_val = FIELD_BITS'(1);
      ecpsm_pkg::SRC_X:   load_val = in_x;
      ecpsm_pkg::SRC_Y:   load_val = in_y;
      ecpsm_pkg::SRC_P:   load_val = p_eff;
      ecpsm_pkg::SRC_A:   load_val = coeff_a;
      default:            load_val = '0;
    endcase

    wr_en   = 1'b0;
    wr_addr = dst_q;
    wr_data = rd_a;
    done    = 1'b0;
    unique case (state)
      D_IDLE: ;
      D_EXEC: begin
        unique case (op_q) inside
          ecpsm_pkg::OP_LOAD: begin
            wr_en = 1'b1; wr_data = load_val; done = 1'b1;
          end
          ecpsm_pkg::OP_MOV: begin
            wr_en = 1'b1; wr_data = rd_a; done = 1'b1;
          end
          ecpsm_pkg::OP_ADD: begin
            wr_en = 1'b1; wr_data = add_r[FIELD_BITS-1:0]; done = 1'b1;
          end
          ecpsm_pkg::OP_SUB: begin
            wr_en = 1'b1; wr_data = sub_r; done = 1'b1;
          end
          ecpsm_pkg::OP_OUT: done = 1'b1;
          default: ;
        endcase
      end
      D_MUL: begin
        if (cnt == CNT_LAST) begin
          wr_en = 1'b1; wr_data = mul_r[FIELD_BITS-1:0]; done = 1'b1;
        end
      end
      D_DIV: begin
        if (cnt == CNT_LAST) begin
          wr_en = 1'b1; wr_data = {shreg[FIELD_BITS-2:0], ge};
        end
      end
      D_REM: begin
        wr_en = 1'b1; wr_addr = ecpsm_pkg::R_REM; wr_data = acc; done = 1'b1;
      end
      default: ;
    endcase
  end

  assign stat.done = done;
  assign stat.zero = zero_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_x <= point_x;
      in_y <= point_y;
    end
    if (cmd.load_out) begin
      result_x           <= cmd.out_inf ? '0 : rd_a;
      result_y           <= cmd.out_inf ? '0 : rd_b;
      result_is_identity <= cmd.out_inf;
    end
    if (wr_en) begin
      zero_q <= (wr_data == '0);
    end
    if (rst) begin
      state <= D_IDLE;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (cmd.start) begin
            rd_a  <= mem[cmd.sa];
            rd_b  <= mem[cmd.sb];
            op_q  <= cmd.op;
            dst_q <= cmd.dst;
            sa_q  <= cmd.sa;
            state <= D_EXEC;
          end
        end
        D_EXEC: begin
          acc <= '0;
          cnt <= '0;
          if (op_q == ecpsm_pkg::OP_MUL) begin
            shreg <= rd_b;
            state <= D_MUL;
          end else if (op_q == ecpsm_pkg::OP_DIV) begin
            shreg <= rd_a;
            state <= D_DIV;
          end else begin
            state <= D_IDLE;
          end
        end
        D_MUL: begin
          acc   <= mul_r[FIELD_BITS-1:0];
          shreg <= {shreg[FIELD_BITS-2:0], 1'b0};
          cnt   <= cnt + CNT_W'(1);
          if (cnt == CNT_LAST) state <= D_IDLE;
        end
        D_DIV: begin
          acc   <= div_rem;
          shreg <= {shreg[FIELD_BITS-2:0], ge};
          cnt   <= cnt + CNT_W'(1);
          if (cnt == CNT_LAST) state <= D_REM;
        end
        D_REM: state <= D_IDLE;
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/ecpsm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ecpsm_ctrl
// Microcoded sequencer: scalar bits, identity flags, call returns, handshakes.
// ----------------------------------------------------------------------------
module ecpsm_ctrl #(
  parameter int SCALAR_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SCALAR_BITS-1:0]  scalar_k,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ecpsm_pkg::dp_cmd_t      dp_cmd,
  input  ecpsm_pkg::dp_stat_t     dp_stat
);

  localparam int IDX_W = (SCALAR_BITS > 1) ? $clog2(SCALAR_BITS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SCALAR_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_HOLD  = 4'b1000
  } state_t;

  state_t                 state;
  ecpsm_pkg::upc_t        pc, ret_p, ret_i, pc_inc;
  ecpsm_pkg::uinstr_t     ui;
  logic [SCALAR_BITS-1:0] k_sh;
  logic [IDX_W-1:0]       bit_idx;
  logic                   acc_inf, add_inf, res_inf, slot_free;

  assign ui        = ecpsm_pkg::ucode(pc);
  assign pc_inc    = pc + ecpsm_pkg::upc_t'(1);
  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    dp_cmd.start    = (state == S_ISSUE) && ecpsm_pkg::is_dp_op(ui.op);
    dp_cmd.op       = ui.op;
    dp_cmd.dst      = ui.dst;
    dp_cmd.sa       = ui.sa;
    dp_cmd.sb       = ui.sb;
    dp_cmd.load_in  = in_valid && in_ready;
    dp_cmd.load_out = slot_free && ((state == S_HOLD) ||
                      ((state == S_WAIT) && dp_stat.done && (ui.op == ecpsm_pkg::OP_OUT)));
    dp_cmd.out_inf  = acc_inf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (dp_cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            k_sh    <= scalar_k;
            bit_idx <= '0;
            acc_inf <= 1'b1;
            add_inf <= 1'b0;
            res_inf <= 1'b0;
            pc      <= '0;
            state   <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          unique case (ui.op) inside
            ecpsm_pkg::OP_LOAD, ecpsm_pkg::OP_MOV, ecpsm_pkg::OP_ADD, ecpsm_pkg::OP_SUB,
            ecpsm_pkg::OP_MUL, ecpsm_pkg::OP_DIV, ecpsm_pkg::OP_OUT: state <= S_WAIT;
            ecpsm_pkg::OP_JMP:      pc <= ui.tgt;
            ecpsm_pkg::OP_BZ:       pc <= dp_stat.zero ? ui.tgt : pc_inc;
            ecpsm_pkg::OP_BNZ:      pc <= dp_stat.zero ? pc_inc : ui.tgt;
            ecpsm_pkg::OP_BNBIT:    pc <= k_sh[0] ? pc_inc : ui.tgt;
            ecpsm_pkg::OP_BACCINF:  pc <= acc_inf ? ui.tgt : pc_inc;
            ecpsm_pkg::OP_BADDINF:  pc <= add_inf ? ui.tgt : pc_inc;
            ecpsm_pkg::OP_CALL: begin
              ret_p <= pc_inc;
              pc    <= ui.tgt;
            end
            ecpsm_pkg::OP_RET:      pc <= ret_p;
            ecpsm_pkg::OP_CALLI: begin
              ret_i <= pc_inc;
              pc    <= ui.tgt;
            end
            ecpsm_pkg::OP_RETI:     pc <= ret_i;
            ecpsm_pkg::OP_ADDINF_SET: begin
              add_inf <= 1'b1;
              pc      <= pc_inc;
            end
            ecpsm_pkg::OP_ACC_FROM_ADD: begin
              acc_inf <= add_inf;
              pc      <= pc_inc;
            end
            ecpsm_pkg::OP_ACC_FROM_RES: begin
              acc_inf <= res_inf;
              pc      <= pc_inc;
            end
            ecpsm_pkg::OP_ADD_FROM_RES: begin
              add_inf <= res_inf;
              pc      <= pc_inc;
            end
            ecpsm_pkg::OP_RES_SET: begin
              res_inf <= 1'b1;
              pc      <= pc_inc;
            end
            ecpsm_pkg::OP_RES_CLR: begin
              res_inf <= 1'b0;
              pc      <= pc_inc;
            end
            ecpsm_pkg::OP_NEXT: begin
              k_sh    <= k_sh >> 1;
              bit_idx <= bit_idx + IDX_W'(1);
              pc      <= (bit_idx == IDX_LAST) ? pc_inc : ui.tgt;
            end
            default: pc <= '0;
          endcase
        end
        S_WAIT: begin
          if (dp_stat.done) begin
            if (ui.op == ecpsm_pkg::OP_OUT) begin
              state <= slot_free ? S_IDLE : S_HOLD;
            end else begin
              pc    <= pc_inc;
              state <= S_ISSUE;
            end
          end
        end
        S_HOLD: begin
          if (slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/ecpsm_chk.sv -----
// ----------------------------------------------------------------------------
// ecpsm_chk
// Port-level checks for the scalar multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module ecpsm_chk #(
  parameter int FIELD_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [FIELD_BITS-1:0] result_x,
  input logic [FIELD_BITS-1:0] result_y,
  input logic                  result_is_identity
);

  // one word in flight: drop ready right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready still high after accept");

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_x) && $stable(result_y) &&
                                $stable(result_is_identity))
    else $error("stalled result word changed");

  // identity reads as the zero pair
  a_identity_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_is_identity |-> result_x == '0 && result_y == '0)
    else $error("identity result with nonzero coordinates");

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind ec_point_scalar_multiply ecpsm_chk #(
  .FIELD_BITS (FIELD_BITS)
) u_ecpsm_chk (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .result_x           (result_x),
  .result_y           (result_y),
  .result_is_identity (result_is_identity)
);

// ----- tb/tb_ec_point_scalar_multiply.sv -----
// ----------------------------------------------------------------------------
// tb_ec_point_scalar_multiply
// Self-checking bench for the elliptic-curve scalar multiplier.
// ----------------------------------------------------------------------------
// Points and scalars go in over the input channel. A software model of
// right-to-left double-and-add forms the expected word for each accepted
// point. Every returned word is checked field by field against the oldest
// expected word. Both channels idle at random. One phase starves the
// output side long enough to stall the input. Another phase drains the block
// part way through a stream. The field registers move between phases
// through small, extreme and non-prime moduli.
// ----------------------------------------------------------------------------
module tb_ec_point_scalar_multiply;

  localparam int FW = 16;
  localparam int KW = 16;

  typedef struct {
    longint unsigned x;
    longint unsigned y;
    logic            inf;
  } curve_point_t;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_ready;
  logic [FW-1:0]                   point_x;
  logic [FW-1:0]                   point_y;
  logic [KW-1:0]                   scalar_k;
  logic                            out_valid;
  logic                            out_ready;
  logic [FW-1:0]                   result_x;
  logic [FW-1:0]                   result_y;
  logic                            result_is_identity;
  logic                            cfg_we;
  logic [ecpsm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [FW-1:0]                   cfg_wdata;

  // shadow copies of the field registers
  logic [FW-1:0] modulus_shadow;
  logic [FW-1:0] coeff_a_shadow;

  curve_point_t product_queue[$];
  int           error_count;
  int           hold_cycles;

  ec_point_scalar_multiply #(
    .FIELD_BITS(FW),
    .SCALAR_BITS(KW)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .point_x(point_x),
    .point_y(point_y),
    .scalar_k(scalar_k),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_x(result_x),
    .result_y(result_y),
    .result_is_identity(result_is_identity),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Field arithmetic. All operands are below p, and p fits in 16 bits, so
  // every product fits comfortably in 64 bits.
  // ---------------------------------------------------------------------------
  function automatic longint unsigned fadd(longint unsigned a, longint unsigned b,
                                           longint unsigned p);
    longint unsigned s;
    s = a + b;
    if (s >= p) s = s - p;
    return s;
  endfunction

  function automatic longint unsigned fsub(longint unsigned a, longint unsigned b,
                                           longint unsigned p);
    return (a >= b) ? a - b : a + (p - b);
  endfunction

  function automatic longint unsigned fmul(longint unsigned a, longint unsigned b,
                                           longint unsigned p);
    return (a * b) % p;
  endfunction

  // Extended Euclid. With a non-prime p the Bezout term is taken as is.
  function automatic longint unsigned finv(longint unsigned a, longint unsigned p);
    longint unsigned r0, r1, t0, t1, q, nr, nt;
    r0 = p;
    r1 = a;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q  = r0 / r1;
      nr = r0 - q * r1;
      nt = fsub(t0, fmul(q % p, t1, p), p);
      r0 = r1;
      r1 = nr;
      t0 = t1;
      t1 = nt;
    end
    return t0;
  endfunction

  function automatic curve_point_t chord_tangent_add(curve_point_t u, curve_point_t v,
                                                     longint unsigned p,
                                                     longint unsigned a);
    curve_point_t    r;
    longint unsigned m, rx;
    if (u.inf) return v;
    if (v.inf) return u;
    r.x   = '0;
    r.y   = '0;
    r.inf = 1'b1;
    if (u.x == v.x) begin
      // P + (-P), or a tangent with y = 0: both give the point at infinity
      if (u.y != v.y || u.y == 0) return r;
      m = fmul(u.x, u.x, p);
      m = fadd(fadd(m, m, p), m, p);
      m = fadd(m, a, p);
      m = fmul(m, finv(fadd(u.y, u.y, p), p), p);
    end else begin
      m = fmul(fsub(u.y, v.y, p), finv(fsub(u.x, v.x, p), p), p);
    end
    rx    = fsub(fsub(fmul(m, m, p), u.x, p), v.x, p);
    r.x   = rx;
    r.y   = fsub(fmul(m, fsub(u.x, rx, p), p), u.y, p);
    r.inf = 1'b0;
    return r;
  endfunction

  function automatic curve_point_t scalar_multiple(logic [FW-1:0] px, logic [FW-1:0] py,
                                                   logic [KW-1:0] k);
    longint unsigned p, a;
    curve_point_t    sum, addend;
    p = (modulus_shadow < 16'd3) ? 64'd3 : 64'(modulus_shadow);
    a = 64'(coeff_a_shadow) % p;
    addend.x   = 64'(px) % p;
    addend.y   = 64'(py) % p;
    addend.inf = (addend.x == 0 && addend.y == 0);
    sum.x   = '0;
    sum.y   = '0;
    sum.inf = 1'b1;
    for (int i = 0; i < KW; i++) begin
      if (k[i]) sum = chord_tangent_add(sum, addend, p, a);
      addend = chord_tangent_add(addend, addend, p, a);
    end
    if (sum.inf) begin
      sum.x = '0;
      sum.y = '0;
    end
    return sum;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: entered and left at a falling edge. Valid stays up across
  // back-to-back words, so it is only lowered when a gap is drawn.
  // ---------------------------------------------------------------------------
  task automatic send_point(logic [FW-1:0] px, logic [FW-1:0] py, logic [KW-1:0] k);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    point_x  <= px;
    point_y  <= py;
    scalar_k <= k;
    do @(posedge clk); while (!in_ready);
    product_queue = {product_queue, scalar_multiple(px, py, k)};
    @(negedge clk);
  endtask

  // Drop valid and hold until every expected word has come back.
  task automatic drain;
    in_valid <= 1'b0;
    while (product_queue.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_field_reg(ecpsm_pkg::cfg_idx_t idx, logic [FW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == ecpsm_pkg::CFG_FIELD_MODULUS) modulus_shadow = value;
    else coeff_a_shadow = value;
    @(negedge clk);
  endtask

  task automatic set_curve(logic [FW-1:0] p, logic [FW-1:0] a);
    drain();
    write_field_reg(ecpsm_pkg::CFG_FIELD_MODULUS, p);
    write_field_reg(ecpsm_pkg::CFG_CURVE_COEFF_A, a);
  endtask

  task automatic send_random_point;
    send_point(FW'($urandom), FW'($urandom), KW'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset curve: field extremes, zero scalar, the identity base point,
  // unreduced coordinates and a point with y zero.
  task automatic test_reset_curve_edges;
    send_point(16'd5, 16'd7, 16'd0);
    send_point(16'd5, 16'd7, 16'd1);
    send_point(16'd0, 16'd0, 16'hFFFF);
    send_point(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_point(16'd65521, 16'd65522, 16'd3);
    send_point(16'd1234, 16'd0, 16'd2);
    send_point(16'd1234, 16'd0, 16'd3);
    send_point(16'd0, 16'd9, 16'h8000);
    send_point(16'h5555, 16'hAAAA, 16'h5555);
  endtask

  // Tiny fields hit the inverse-pair and y-zero doublings all the time.
  task automatic test_small_fields;
    set_curve(16'd3, 16'd0);
    send_point(16'd1, 16'd1, 16'd2);
    send_point(16'd2, 16'd0, 16'd7);
    // modulus below three is used as three
    set_curve(16'd0, 16'hFFFF);
    send_point(16'd4, 16'd5, 16'hFFFF);
    send_point(16'd1, 16'd2, 16'd6);
    set_curve(16'd7, 16'd3);
    for (int i = 0; i < 6; i++) send_point(FW'($urandom_range(0, 6)),
                                            FW'($urandom_range(0, 6)), KW'($urandom));
  endtask

  // Largest modulus, which is not prime.
  task automatic test_composite_modulus;
    set_curve(16'hFFFF, 16'hFFFF);
    send_point(16'hFFFE, 16'h0001, 16'hFFFF);
    send_point(16'd3, 16'd5, 16'h00FF);
    send_point(16'h8000, 16'h7FFF, 16'h1234);
  endtask

  // Bulk random traffic over a spread of curves.
  task automatic test_random_traffic;
    logic [FW-1:0] primes[6] = '{16'd97, 16'd251, 16'd4093, 16'd65521, 16'd11, 16'd65519};
    logic [FW-1:0] p;
    for (int phase = 0; phase < 6; phase++) begin
      p = primes[phase];
      set_curve(p, FW'($urandom));
      for (int i = 0; i < 18; i++) begin
        if (p < 300 && $urandom_range(0, 1) == 1)
          send_point(FW'($urandom_range(0, p - 1)), FW'($urandom_range(0, p - 1)),
                     KW'($urandom));
        else
          send_random_point();
      end
    end
  endtask

  // Starve the output side so the result slot and the sequencer both fill,
  // then let the sender keep offering words against a stalled input.
  task automatic test_output_backpressure;
    set_curve(16'd65521, 16'd65518);
    hold_cycles = 150000;
    for (int i = 0; i < 6; i++) send_random_point();
  endtask

  // Drain part way through a stream, then resume.
  task automatic test_sender_pause;
    for (int i = 0; i < 5; i++) send_random_point();
    drain();
    for (int i = 0; i < 5; i++) send_random_point();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker: random stalls per word, plus the long hold.
  // ---------------------------------------------------------------------------
  initial begin
    curve_point_t want;
    int           stall;
    stall     = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (product_queue.size() == 0) begin
          $display("%0t: unexpected word x=%0d y=%0d inf=%0b", $time,
                   result_x, result_y, result_is_identity);
          error_count++;
        end else begin
          want = product_queue.pop_front();
          if (result_x !== want.x[FW-1:0]) begin
            $display("%0t: result_x expected %0d actual %0d", $time, want.x, result_x);
            error_count++;
          end
          if (result_y !== want.y[FW-1:0]) begin
            $display("%0t: result_y expected %0d actual %0d", $time, want.y, result_y);
            error_count++;
          end
          if (result_is_identity !== want.inf) begin
            $display("%0t: result_is_identity expected %0b actual %0b", $time,
                     want.inf, result_is_identity);
            error_count++;
          end
        end
        stall = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) stall = 0;
      end
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Limit: far beyond the slowest legal run.
  initial begin
    #600000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    error_count    = 0;
    hold_cycles    = 0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    point_x        = '0;
    point_y        = '0;
    scalar_k       = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    modulus_shadow = 16'd65521;
    coeff_a_shadow = 16'd65518;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_curve_edges();
    test_small_fields();
    test_composite_modulus();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic();

    drain();
    repeat (200) @(negedge clk);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ecpsm_pkg.sv
rtl/ecpsm_dp.sv
rtl/ecpsm_ctrl.sv
rtl/ec_point_scalar_multiply.sv
rtl/ecpsm_chk.sv
tb/tb_ec_point_scalar_multiply.sv
